/* rtl/mhpp_pkg.sv */
// Shared types, constants and the hex digit decoder for the masked hex pattern parser.
package mhpp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QIdxW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] ChSpace = 8'h20;
	localparam logic [CharW-1:0] ChOpen  = 8'h5B;
	localparam logic [CharW-1:0] ChClose = 8'h5D;
	localparam logic [2:0]       TopBit  = 3'd7;

	typedef struct packed {
		logic [ByteW-1:0] value;
		logic [ByteW-1:0] mask;
		logic             final_byte;
		logic             has_byte;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_of(input logic [CharW-1:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.nibble = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nibble = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nibble = 4'(c - 8'h61 + 8'd10);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

/* rtl/mhpp_core.sv */
// Parser state and the per-character step that yields up to two results.
module mhpp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [mhpp_pkg::CharW-1:0]  character,
	input  logic                        last_char,
	output mhpp_pkg::step_out_t         step
);
	import mhpp_pkg::*;

	logic             bit_mode_q, bit_mode_d;
	logic [2:0]       slot_q, slot_d;
	logic             phase_q, phase_d;
	logic [ByteW-1:0] value_q, value_d;
	logic [ByteW-1:0] mask_q, mask_d;
	logic             present_q, present_d;

	always_comb begin
		hex_t    h;
		logic    start;
		logic    phase_n;
		result_t held_r;
		result_t end_r;
		h          = hex_of(character);
		start      = 1'b0;
		phase_n    = ~phase_q;
		bit_mode_d = bit_mode_q;
		slot_d     = slot_q;
		phase_d    = phase_q;
		value_d    = value_q;
		mask_d     = mask_q;
		present_d  = present_q;
		step       = '0;
		held_r     = '{value: value_q, mask: mask_q, final_byte: 1'b0, has_byte: 1'b1};
		end_r      = '0;

		priority if (character == ChSpace || character[CharW-1]) begin
			// skip
		end else if (character == ChOpen) begin
			bit_mode_d = 1'b1;
			slot_d     = 3'd0;
		end else if (character == ChClose) begin
			bit_mode_d = 1'b0;
			slot_d     = 3'd0;
		end else if (!bit_mode_q) begin
			phase_d = phase_n;
			start   = phase_n;
			if (start) begin
				value_d   = '0;
				mask_d    = '0;
				present_d = 1'b1;
			end
			if (h.is_hex) begin
				value_d = value_d | (ByteW'(h.nibble) << (phase_n ? 3'd4 : 3'd0));
				mask_d  = mask_d  | (ByteW'(4'hF)     << (phase_n ? 3'd4 : 3'd0));
			end
		end else begin
			if (slot_q == 3'd0) begin
				start     = 1'b1;
				phase_d   = 1'b0;
				slot_d    = TopBit;
				value_d   = '0;
				mask_d    = '0;
				present_d = 1'b1;
			end else begin
				slot_d = slot_q - 3'd1;
			end
			if (h.is_hex) begin
				value_d = value_d | (ByteW'(h.nibble[0]) << slot_d);
				mask_d  = mask_d  | (ByteW'(1'b1)        << slot_d);
			end
		end

		// Emit the held byte when a new one opens over it.
		if (start && present_q) begin
			step.r0    = held_r;
			step.count = 2'd1;
		end

		if (last_char) begin
			end_r = '{value: value_d, mask: mask_d, final_byte: 1'b1, has_byte: present_d};
			if (!present_d) begin
				end_r.value = '0;
				end_r.mask  = '0;
			end
			if (step.count == 2'd1) begin
				step.r1    = end_r;
				step.count = 2'd2;
			end else begin
				step.r0    = end_r;
				step.count = 2'd1;
			end
			bit_mode_d = 1'b0;
			slot_d     = 3'd0;
			phase_d    = 1'b0;
			value_d    = '0;
			mask_d     = '0;
			present_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_mode_q <= 1'b0;
			slot_q     <= 3'd0;
			phase_q    <= 1'b0;
			value_q    <= '0;
			mask_q     <= '0;
			present_q  <= 1'b0;
		end else if (fire) begin
			bit_mode_q <= bit_mode_d;
			slot_q     <= slot_d;
			phase_q    <= phase_d;
			value_q    <= value_d;
			mask_q     <= mask_d;
			present_q  <= present_d;
		end
	end

endmodule

/* rtl/mhpp_fifo.sv */
// Small result queue that takes up to two results per cycle and gives one.
module mhpp_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mhpp_pkg::step_out_t          push,
	input  logic                         pop,
	output logic                         room,
	output logic                         not_empty,
	output mhpp_pkg::result_t            head
);
	import mhpp_pkg::*;

	result_t          mem_q [QDepth];
	logic [QIdxW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;

	// Room for a worst-case step of two results.
	assign room      = cnt_q <= QCntW'(QDepth - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + QIdxW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QIdxW'(push.count);
			rd_q  <= rd_q + QIdxW'(pop);
			cnt_q <= cnt_q + QCntW'(push.count) - QCntW'(pop);
		end
	end

endmodule

/* rtl/masked_hex_pattern_parser_top.sv */
// Top level of the masked hex pattern parser: input register, parser step, result queue.
// Path: a character waits in the input register, and its results enter the result queue;
// a second result of the same character leaves the queue after the first.
// Throughput: one character per cycle while out_stall is low and each yields at most one
// result; a character that yields two (byte boundary plus end of string) drains at one result
// per cycle, set by the single output port of the four-entry result queue.
// Reset: arst_n clears parser state, the input register valid and the queue pointers.
module masked_hex_pattern_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mhpp_pkg::CharW-1:0]  character,
	input  logic                        last_char,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mhpp_pkg::ByteW-1:0]  pattern_value,
	output logic [mhpp_pkg::ByteW-1:0]  pattern_mask,
	output logic                        final_byte,
	output logic                        has_byte
);
	import mhpp_pkg::*;

	// Input register: holds one character until the queue has room for its results.
	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	logic      room;
	logic      fire;
	logic      in_take;
	step_out_t step;
	step_out_t push;
	result_t   head;

	// Process the held character when the queue can absorb two results.
	assign fire     = valid_s1 && room;
	// Stall only when the held character cannot advance this cycle.
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	mhpp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.character (char_s1),
		.last_char (last_s1),
		.step      (step)
	);

	// Drop the step's results unless the character really advances.
	always_comb begin
		push = step;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	mhpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && !out_stall),
		.room      (room),
		.not_empty (out_valid),
		.head      (head)
	);

	assign pattern_value = head.value;
	assign pattern_mask  = head.mask;
	assign final_byte    = head.final_byte;
	assign has_byte      = head.has_byte;

endmodule

/* rtl/mhpp_checker.sv */
// Port-level checks for the masked hex pattern parser, bound to the top level.
module mhpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pattern_value,
	input logic [7:0] pattern_mask,
	input logic       final_byte,
	input logic       has_byte
);

	a_value_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pattern_value & ~pattern_mask) == 8'h00)
		else $error("value bit set outside mask");

	a_marker_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> final_byte)
		else $error("end marker without final flag");

	a_marker_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (pattern_value == 8'h00 && pattern_mask == 8'h00))
		else $error("end marker carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pattern_value)
			&& $stable(pattern_mask) && $stable(final_byte) && $stable(has_byte)))
		else $error("stalled result changed");

endmodule

bind masked_hex_pattern_parser_top mhpp_checker u_mhpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.pattern_value (pattern_value),
	.pattern_mask  (pattern_mask),
	.final_byte    (final_byte),
	.has_byte      (has_byte)
);
